// ----- design/assert_macros.svh -----
// assertion macros used by the checker file tq_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with reset disable
`define TQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("timer queue check failed");

// implication from a condition to a same-cycle consequence
`define TQ_ASSERT_IMP(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("timer queue check failed");

`endif

// ----- design/tq_pkg.sv -----
// ----------------------------------------------------------------------------
// tq_pkg
// types, codes and sizes shared by the delta list timer queue
// ----------------------------------------------------------------------------
`default_nettype none

package tq_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int SEQ_W   = 16;
    localparam int DLY_W   = 32;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_CANCEL = 2'd1,
        FN_POP    = 2'd2,
        FN_TICK   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_NEW,
        S_SUCC,
        S_PRED,
        S_HEAD_RD,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [DLY_W-1:0] delta;
        logic [IDX_W-1:0] link;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        status_t          status;
        logic             expired;
        logic [SEQ_W-1:0] head_seq;
        logic [CNT_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

// ----- design/tq_mem.sv -----
// ----------------------------------------------------------------------------
// tq_mem
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module tq_mem (
    input  wire             clk,
    input  tq_pkg::mem_wr_t wr,
    input  tq_pkg::mem_rd_t rd,
    output tq_pkg::entry_t  rdata
);
    import tq_pkg::*;

    entry_t mem [ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/tq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tq_ctrl
// sequencer: walks the linked list in memory and patches entries back
// ----------------------------------------------------------------------------
`default_nettype none

module tq_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire  [1:0]              func,
    input  wire  [tq_pkg::SEQ_W-1:0] seq,
    input  wire  [tq_pkg::DLY_W-1:0] delay,
    output logic                    res_valid,
    input  wire                     res_ready,
    output tq_pkg::result_t         res,
    output tq_pkg::mem_wr_t         mem_wr,
    output tq_pkg::mem_rd_t         mem_rd,
    input  tq_pkg::entry_t          rdata
);
    import tq_pkg::*;

    state_t           state_reg, state_next;
    func_t            func_reg, func_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [DLY_W-1:0] delay_reg, delay_next;
    status_t          status_reg, status_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ENTRIES-1:0] used_reg, used_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [DLY_W-1:0] sum_reg, sum_next;
    logic             dup_reg, dup_next;
    logic             brk_reg, brk_next;
    logic             found_reg, found_next;
    logic             hp_reg, hp_next;
    logic             act_reg, act_next;
    logic [IDX_W-1:0] prev_slot_reg, prev_slot_next;
    entry_t           prev_word_reg, prev_word_next;
    logic [IDX_W-1:0] succ_slot_reg, succ_slot_next;
    entry_t           succ_word_reg, succ_word_next;
    logic [IDX_W-1:0] tgt_slot_reg, tgt_slot_next;
    entry_t           tgt_word_reg, tgt_word_next;
    logic [CNT_W-1:0] tgt_pos_reg, tgt_pos_next;
    logic [IDX_W-1:0] free_reg, free_next;

    logic             accept;
    logic             walk_more;
    logic [IDX_W-1:0] free_slot;
    logic [DLY_W-1:0] new_delta;
    logic [DLY_W:0]   run_end;
    logic             match;

    assign accept    = in_valid && in_ready;
    assign walk_more = (pos_reg + 1'b1) < len_reg;
    assign new_delta = delay_reg - sum_reg;
    assign run_end   = {1'b0, sum_reg} + {1'b0, rdata.delta};
    assign match     = (func_reg == FN_CANCEL) ? (rdata.seq == seq_reg)
                                               : (pos_reg == '0);

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (count_reg != '0)
                    begin
                        state_next = S_WALK;
                    end
                    else if (func_t'(func) == FN_INSERT)
                    begin
                        state_next = S_NEW;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
            end
            S_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = S_NEW;
                end
            end
            S_NEW:     state_next = S_SUCC;
            S_SUCC:    state_next = S_PRED;
            S_PRED:    state_next = S_HEAD_RD;
            S_HEAD_RD: state_next = S_RESP;
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs: handshake, memory ports, result
    always_comb
    begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_rd.en   = 1'b0;
        mem_rd.addr = head_reg;
        mem_wr.en   = 1'b0;
        mem_wr.addr = tgt_slot_reg;
        mem_wr.data = tgt_word_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                mem_rd.en = 1'b1;
            end
            S_WALK:
            begin
                mem_rd.en   = walk_more;
                mem_rd.addr = rdata.link;
            end
            S_NEW:
            begin
                if (func_reg == FN_INSERT)
                begin
                    mem_wr.en   = !dup_reg && (count_reg != CNT_W'(ENTRIES));
                    mem_wr.addr = free_slot;
                    mem_wr.data.seq   = seq_reg;
                    mem_wr.data.delta = new_delta;
                    mem_wr.data.link  = brk_reg ? succ_slot_reg : '0;
                end
                else if (func_reg == FN_TICK)
                begin
                    mem_wr.en   = 1'b1;
                    mem_wr.data.delta = (tgt_word_reg.delta > delay_reg)
                                      ? tgt_word_reg.delta - delay_reg : '0;
                end
            end
            S_SUCC:
            begin
                mem_wr.addr = succ_slot_reg;
                mem_wr.data = succ_word_reg;
                if (func_reg == FN_INSERT)
                begin
                    mem_wr.en = act_reg && brk_reg;
                    mem_wr.data.delta = succ_word_reg.delta - new_delta;
                end
                else
                begin
                    // not the tail: count has already dropped by one
                    mem_wr.en = act_reg && (tgt_pos_reg != count_reg);
                    mem_wr.data.delta = succ_word_reg.delta + tgt_word_reg.delta;
                end
            end
            S_PRED:
            begin
                mem_wr.en   = act_reg && hp_reg;
                mem_wr.addr = prev_slot_reg;
                mem_wr.data = prev_word_reg;
                mem_wr.data.link = (func_reg == FN_INSERT) ? free_reg : tgt_word_reg.link;
            end
            S_HEAD_RD:
            begin
                mem_rd.en = 1'b1;
            end
            S_RESP:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase

        res.status   = status_reg;
        res.count    = count_reg;
        res.expired  = (count_reg != '0) && (rdata.delta == '0);
        res.head_seq = (count_reg != '0) ? rdata.seq : '0;
    end

    // datapath next values
    always_comb
    begin
        func_next      = func_reg;
        seq_next       = seq_reg;
        delay_next     = delay_reg;
        status_next    = status_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        dup_next       = dup_reg;
        brk_next       = brk_reg;
        found_next     = found_reg;
        hp_next        = hp_reg;
        act_next       = act_reg;
        prev_slot_next = prev_slot_reg;
        prev_word_next = prev_word_reg;
        succ_slot_next = succ_slot_reg;
        succ_word_next = succ_word_reg;
        tgt_slot_next  = tgt_slot_reg;
        tgt_word_next  = tgt_word_reg;
        tgt_pos_next   = tgt_pos_reg;
        free_next      = free_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func_t'(func);
                    seq_next    = seq;
                    delay_next  = delay;
                    cur_next    = head_reg;
                    pos_next    = '0;
                    sum_next    = '0;
                    dup_next    = 1'b0;
                    brk_next    = 1'b0;
                    found_next  = 1'b0;
                    hp_next     = 1'b0;
                    act_next    = 1'b0;
                    status_next = ST_OK;
                    case (func_t'(func))
                        FN_INSERT: len_next = count_reg;
                        FN_CANCEL: len_next = count_reg;
                        FN_POP:    len_next = (count_reg > CNT_W'(1)) ? CNT_W'(2) : CNT_W'(1);
                        default:   len_next = CNT_W'(1);
                    endcase
                    if (count_reg == '0)
                    begin
                        if (func_t'(func) == FN_CANCEL)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else if (func_t'(func) != FN_INSERT)
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                end
            end
            S_WALK:
            begin
                pos_next = pos_reg + 1'b1;
                cur_next = rdata.link;
                if (func_reg == FN_INSERT)
                begin
                    if (rdata.seq == seq_reg)
                    begin
                        dup_next = 1'b1;
                    end
                    if (!brk_reg)
                    begin
                        if (run_end > {1'b0, delay_reg})
                        begin
                            brk_next       = 1'b1;
                            succ_slot_next = cur_reg;
                            succ_word_next = rdata;
                        end
                        else
                        begin
                            sum_next       = run_end[DLY_W-1:0];
                            prev_slot_next = cur_reg;
                            prev_word_next = rdata;
                            hp_next        = 1'b1;
                        end
                    end
                end
                else if (func_reg == FN_TICK)
                begin
                    tgt_slot_next = cur_reg;
                    tgt_word_next = rdata;
                end
                else if (!found_reg)
                begin
                    if (match)
                    begin
                        found_next    = 1'b1;
                        tgt_slot_next = cur_reg;
                        tgt_word_next = rdata;
                        tgt_pos_next  = pos_reg;
                    end
                    else
                    begin
                        prev_slot_next = cur_reg;
                        prev_word_next = rdata;
                        hp_next        = 1'b1;
                    end
                end
                else if (pos_reg == tgt_pos_reg + 1'b1)
                begin
                    succ_slot_next = cur_reg;
                    succ_word_next = rdata;
                end
            end
            S_NEW:
            begin
                if (func_reg == FN_INSERT)
                begin
                    if (dup_reg)
                    begin
                        status_next = ST_DUP;
                    end
                    else if (count_reg == CNT_W'(ENTRIES))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        act_next             = 1'b1;
                        free_next            = free_slot;
                        used_next[free_slot] = 1'b1;
                        count_next           = count_reg + 1'b1;
                        if (!hp_reg)
                        begin
                            head_next = free_slot;
                        end
                    end
                end
                else if (func_reg != FN_TICK && status_reg == ST_OK)
                begin
                    if (!found_reg)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else
                    begin
                        act_next                = 1'b1;
                        used_next[tgt_slot_reg] = 1'b0;
                        count_next              = count_reg - 1'b1;
                        if (count_reg == CNT_W'(1))
                        begin
                            head_next = '0;
                        end
                        else if (!hp_reg)
                        begin
                            head_next = tgt_word_reg.link;
                        end
                    end
                end
            end
            default:
            begin
                act_next = act_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        seq_reg       <= seq_next;
        delay_reg     <= delay_next;
        status_reg    <= status_next;
        cur_reg       <= cur_next;
        pos_reg       <= pos_next;
        len_reg       <= len_next;
        sum_reg       <= sum_next;
        dup_reg       <= dup_next;
        brk_reg       <= brk_next;
        found_reg     <= found_next;
        hp_reg        <= hp_next;
        act_reg       <= act_next;
        prev_slot_reg <= prev_slot_next;
        prev_word_reg <= prev_word_next;
        succ_slot_reg <= succ_slot_next;
        succ_word_reg <= succ_word_next;
        tgt_slot_reg  <= tgt_slot_next;
        tgt_word_reg  <= tgt_word_next;
        tgt_pos_reg   <= tgt_pos_next;
        free_reg      <= free_next;
    end

endmodule

`default_nettype wire

// ----- design/delta_list_timer_queue.sv -----
// pop, tick or cancel on an empty list skip the walk and the write-back
// insert and cancel walk every held entry, one per cycle
// pop walks up to two entries, tick one; the one read port of the list memory sets the pace
// one item at a time; the next input beat is taken once the result is registered
// reset: asynchronous, empties the list; entry contents stay undefined
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// timer queue held as a delta list in a linked entry memory
// ----------------------------------------------------------------------------
`default_nettype none

module delta_list_timer_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  [1:0]               func,
    input  wire  [tq_pkg::SEQ_W-1:0] seq,
    input  wire  [tq_pkg::DLY_W-1:0] delay,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic [2:0]               status,
    output logic                     expired,
    output logic [tq_pkg::SEQ_W-1:0] head_seq,
    output logic [tq_pkg::CNT_W-1:0] count
);
    import tq_pkg::*;

    mem_wr_t mem_wr;
    mem_rd_t mem_rd;
    entry_t  rdata;
    result_t res;
    logic    res_valid;
    logic    res_ready;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    tq_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .rd    (mem_rd),
        .rdata (rdata)
    );

    tq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .seq       (seq),
        .delay     (delay),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_wr    (mem_wr),
        .mem_rd    (mem_rd),
        .rdata     (rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_reg.status;
    assign expired   = out_reg.expired;
    assign head_seq  = out_reg.head_seq;
    assign count     = out_reg.count;

endmodule

`default_nettype wire

// ----- design/tq_checker.sv -----
// ----------------------------------------------------------------------------
// tq_checker
// port-level checks on the timer queue result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tq_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      out_valid,
    input wire                      out_ready,
    input wire [2:0]                status,
    input wire                      expired,
    input wire [tq_pkg::SEQ_W-1:0]  head_seq,
    input wire [tq_pkg::CNT_W-1:0]  count
);
    import tq_pkg::*;

    // count stays within the table
    `TQ_ASSERT_IMP(a_count_range, clk, rst_n, out_valid, count <= CNT_W'(ENTRIES))
    // expiry only with a held head
    `TQ_ASSERT_IMP(a_exp_nonempty, clk, rst_n, out_valid && expired, count != '0)
    // empty list reports head zero
    `TQ_ASSERT_IMP(a_empty_head, clk, rst_n, out_valid && count == '0, head_seq == '0)
    // full refusal only with a full table
    `TQ_ASSERT_IMP(a_full_count, clk, rst_n, out_valid && status == ST_FULL,
                   count == CNT_W'(ENTRIES))
    // stalled beat holds
    `TQ_ASSERT(a_out_hold, clk, rst_n,
               out_valid && !out_ready |=> out_valid && $stable(count) && $stable(status))

endmodule

bind delta_list_timer_queue tq_checker u_tq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .expired   (expired),
    .head_seq  (head_seq),
    .count     (count)
);

`default_nettype wire
